FILE: design/svmd_pkg.sv
// ----------------------------------------------------------------------------
// svmd_pkg: shared constants for the series mean and deviation block
// Field widths, register indexes, status codes and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package svmd_pkg;

	// Default parameter values
	localparam int DEF_MAX_COUNT   = 131072;
	localparam int DEF_SAMPLE_BITS = 24;

	// Result field widths
	localparam int MEAN_W   = 25;
	localparam int STD_W    = 25;
	localparam int COUNT_W  = 18;
	localparam int STATUS_W = 2;

	localparam int OUT_FIELDS_W = MEAN_W + STD_W + COUNT_W + STATUS_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Saturating count of every sample seen in a series
	localparam int                SEEN_W   = 18;
	localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DIFF_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT = 1'd1;

	localparam logic [CFG_DATA_W-1:0] SKIP_RESET = 16'd500;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_TOO_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

FILE: design/svmd_addsub.sv
// ----------------------------------------------------------------------------
// svmd_addsub: shared adder / subtractor
// Adds or subtracts two words; the carry out doubles as "a >= b" on subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module svmd_addsub #(
	parameter int W = 87
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,
	output logic      [W-1:0] res,
	output logic              cout
);

	logic [W:0] full;
	logic [W-1:0] b_inv;

	// Invert b and add one on subtract
	assign b_inv = sub ? ~b : b;
	assign full  = {1'b0, a} + {1'b0, b_inv} + {{W{1'b0}}, sub};
	assign res   = full[W-1:0];
	assign cout  = full[W];

endmodule

`default_nettype wire

FILE: design/series_velocity_mean_and_deviation_top.sv
// ----------------------------------------------------------------------------
// series_velocity_mean_and_deviation_top: series mean and sample deviation
//
// Samples arrive as words on the s_ channel, one signed value in s_tdata and
// s_tlast on the final word of a series. In difference mode each value is
// the step from the previous sample and the first skip_count values are
// dropped; otherwise the samples are used as they are. The last word of a
// series produces one result word on the m_ channel: floor mean, floor
// sample standard deviation, kept count and a status code.
// A sample that enters the statistics passes the square, sum-of-squares and
// sum states; a dropped one is taken in the idle state alone. The end of a
// series is run by the one shared adder, which does the divide, multiply
// and square root steps one bit at a time.
// s_tready is high only while the sequencer waits for a word. A result waits
// in the output register until taken; while it waits a following series is
// accepted, and its own result holds the sequencer until the register frees.
// Reset loads difference mode 1 and skip count 500 and clears all series
// state; configuration is written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
`default_nettype none

module series_velocity_mean_and_deviation_top
	import svmd_pkg::*;
#(
	parameter int MAX_COUNT   = DEF_MAX_COUNT,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// sample words
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // sample
	input  wire logic                   s_tlast,   // end_of_series
	// result words
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata    // mean_value, std_dev, kept_count, status
);

	localparam int VAL_W  = SAMPLE_BITS + 1;
	localparam int CNT_W  = $clog2(MAX_COUNT + 1);
	localparam int SUM_W  = VAL_W + CNT_W;
	localparam int SQ_W   = 2 * VAL_W;
	localparam int SSQ_W  = SQ_W + CNT_W;
	localparam int NUM_W  = SSQ_W + CNT_W;
	localparam int D_W    = 2 * CNT_W;
	localparam int RT_W   = (NUM_W + 1) / 2;
	localparam int U_W    = NUM_W + 1;
	localparam int STEP_W = $clog2(NUM_W + 1);
	localparam int PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;

	// Sequencer states
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SQUARE  = 4'd1;
	localparam logic [3:0] ST_ACC_SQ  = 4'd2;
	localparam logic [3:0] ST_ACC_SUM = 4'd3;
	localparam logic [3:0] ST_FIN     = 4'd4;
	localparam logic [3:0] ST_MEAN    = 4'd5;
	localparam logic [3:0] ST_MULN    = 4'd6;
	localparam logic [3:0] ST_SUBSQ   = 4'd7;
	localparam logic [3:0] ST_DEN     = 4'd8;
	localparam logic [3:0] ST_DIV     = 4'd9;
	localparam logic [3:0] ST_SQRT    = 4'd10;
	localparam logic [3:0] ST_OUT     = 4'd11;

	logic [3:0] state_q;

	// Configuration registers
	logic                  diff_mode_q;
	logic [CFG_DATA_W-1:0] skip_q;

	// Series state
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic [SEEN_W-1:0]             seen_q;
	logic [CNT_W-1:0]              kept_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SSQ_W-1:0]              ssq_q;
	logic                          ovf_q;

	// Per-word work registers
	logic signed [VAL_W-1:0] value_q;
	logic                    last_q;
	logic [SQ_W-1:0]         prod_q;

	// Finish sequence registers
	logic [STEP_W-1:0]       step_q;
	logic                    sneg_q;
	logic [U_W-1:0]          rem_q;
	logic [U_W-1:0]          num_q;
	logic [U_W-1:0]          mcand_q;
	logic [SUM_W-1:0]        mplier_q;
	logic [D_W-1:0]          den_q;
	logic [SUM_W-1:0]        mean_q;
	logic [RT_W-1:0]         root_q;

	// Output register
	logic                    m_tvalid_q;
	logic [MEAN_W-1:0]       out_mean_q;
	logic [STD_W-1:0]        out_std_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic [STATUS_W-1:0]     out_status_q;

	// Shared unit
	logic [U_W-1:0] alu_a;
	logic [U_W-1:0] alu_b;
	logic           alu_sub;
	logic [U_W-1:0] alu_res;
	logic           alu_cout;

	svmd_addsub #(
		.W(U_W)
	) u_addsub (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res),
		.cout(alu_cout)
	);

	// Decode the incoming word
	logic signed [SAMPLE_BITS-1:0] cur_s;
	logic signed [VAL_W-1:0]       in_value;
	logic                          in_keep;
	logic                          kept_full;
	logic                          in_add;

	assign cur_s     = signed'(s_tdata[SAMPLE_BITS-1:0]);
	assign in_value  = (diff_mode_q && (seen_q != '0)) ?
	                   VAL_W'(cur_s) - VAL_W'(prev_q) : VAL_W'(cur_s);
	assign in_keep   = !(diff_mode_q && (seen_q < SEEN_W'(skip_q)));
	assign kept_full = kept_q >= CNT_W'(MAX_COUNT);
	assign in_add    = in_keep && !kept_full;

	// Magnitudes for the multiplier and the divide steps
	logic [VAL_W-1:0] val_mag;
	logic [SQ_W-1:0]  sq;
	logic [SUM_W-1:0] sum_mag;

	assign val_mag = value_q[VAL_W-1] ? VAL_W'(-value_q) : VAL_W'(value_q);
	assign sq      = val_mag * val_mag;
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// Mean quotient and remainder after the current divide step
	logic [SUM_W-1:0] mean_qv;
	logic [U_W-1:0]   rem_nx;
	logic [SUM_W-1:0] mean_nx;

	assign mean_qv = {mplier_q[SUM_W-2:0], alu_cout};
	assign rem_nx  = alu_cout ? alu_res : alu_a;
	assign mean_nx = !sneg_q ? mean_qv :
	                 (rem_nx != '0) ? ~mean_qv : SUM_W'(-mean_qv);

	logic step_last;
	assign step_last = (step_q == STEP_W'(1));

	// Load the output register when the result is ready and the slot is free
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// Route operands to the shared unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_ACC_SQ: begin
				alu_a = U_W'(ssq_q);
				alu_b = U_W'(prod_q);
			end
			ST_ACC_SUM: begin
				alu_a = U_W'(sum_q);
				alu_b = U_W'(value_q);
			end
			ST_MEAN: begin
				alu_a   = {rem_q[U_W-2:0], mplier_q[SUM_W-1]};
				alu_b   = U_W'(kept_q);
				alu_sub = 1'b1;
			end
			ST_MULN: begin
				alu_a = num_q;
				alu_b = mplier_q[0] ? mcand_q : '0;
			end
			ST_SUBSQ: begin
				alu_a   = num_q;
				alu_b   = mplier_q[0] ? mcand_q : '0;
				alu_sub = 1'b1;
			end
			ST_DEN: begin
				alu_a = U_W'(den_q);
				alu_b = mplier_q[0] ? mcand_q : '0;
			end
			ST_DIV: begin
				alu_a   = {rem_q[U_W-2:0], num_q[NUM_W-1]};
				alu_b   = U_W'(den_q);
				alu_sub = 1'b1;
			end
			ST_SQRT: begin
				alu_a   = {rem_q[U_W-3:0], num_q[2*RT_W-1 -: 2]};
				alu_b   = U_W'({root_q, 2'b01});
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_mode_q <= 1'b1;
			skip_q      <= SKIP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIFF_MODE:  diff_mode_q <= cfg_data[0];
				REG_SKIP_COUNT: skip_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prev_q     <= '0;
			seen_q     <= '0;
			kept_q     <= '0;
			sum_q      <= '0;
			ssq_q      <= '0;
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Raise valid on a new result, drop it once the receiver takes it
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						prev_q  <= cur_s;
						value_q <= in_value;
						last_q  <= s_tlast;
						if (seen_q != SEEN_MAX) begin
							seen_q <= seen_q + SEEN_W'(1);
						end
						if (in_keep && kept_full) begin
							ovf_q <= 1'b1;
						end
						if (in_add) begin
							kept_q  <= kept_q + CNT_W'(1);
							state_q <= ST_SQUARE;
						end else if (s_tlast) begin
							state_q <= ST_FIN;
						end
					end
				end

				ST_SQUARE: begin
					prod_q  <= sq;
					state_q <= ST_ACC_SQ;
				end

				ST_ACC_SQ: begin
					ssq_q   <= alu_res[SSQ_W-1:0];
					state_q <= ST_ACC_SUM;
				end

				ST_ACC_SUM: begin
					sum_q   <= signed'(alu_res[SUM_W-1:0]);
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end

				// Set up the mean divide, or skip straight to the result
				ST_FIN: begin
					root_q <= '0;
					if (kept_q == '0) begin
						mean_q  <= '0;
						state_q <= ST_OUT;
					end else begin
						sneg_q   <= sum_q[SUM_W-1];
						mplier_q <= sum_mag;
						rem_q    <= '0;
						step_q   <= STEP_W'(SUM_W);
						state_q  <= ST_MEAN;
					end
				end

				// One quotient bit of |sum| / n per cycle
				ST_MEAN: begin
					rem_q <= rem_nx;
					if (step_last) begin
						mean_q <= mean_nx;
						if (kept_q < CNT_W'(2)) begin
							state_q <= ST_OUT;
						end else begin
							num_q    <= '0;
							mcand_q  <= U_W'(ssq_q);
							mplier_q <= SUM_W'(kept_q);
							step_q   <= STEP_W'(CNT_W);
							state_q  <= ST_MULN;
						end
					end else begin
						mplier_q <= mean_qv;
						step_q   <= step_q - STEP_W'(1);
					end
				end

				// n * sumsq, one multiplier bit per cycle
				ST_MULN: begin
					num_q <= alu_res;
					if (step_last) begin
						mcand_q  <= U_W'(sum_mag);
						mplier_q <= sum_mag;
						step_q   <= STEP_W'(SUM_W);
						state_q  <= ST_SUBSQ;
					end else begin
						mcand_q  <= {mcand_q[U_W-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
						step_q   <= step_q - STEP_W'(1);
					end
				end

				// Subtract sum^2, one partial product per cycle
				ST_SUBSQ: begin
					num_q <= alu_res;
					if (step_last) begin
						den_q    <= '0;
						mcand_q  <= U_W'(kept_q);
						mplier_q <= SUM_W'(kept_q) - SUM_W'(1);
						step_q   <= STEP_W'(CNT_W);
						state_q  <= ST_DEN;
					end else begin
						mcand_q  <= {mcand_q[U_W-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
						step_q   <= step_q - STEP_W'(1);
					end
				end

				// n * (n - 1)
				ST_DEN: begin
					den_q <= alu_res[D_W-1:0];
					if (step_last) begin
						rem_q   <= '0;
						step_q  <= STEP_W'(NUM_W);
						state_q <= ST_DIV;
					end else begin
						mcand_q  <= {mcand_q[U_W-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
						step_q   <= step_q - STEP_W'(1);
					end
				end

				// Restoring divide; quotient bits shift into num_q
				ST_DIV: begin
					num_q <= {1'b0, num_q[NUM_W-2:0], alu_cout};
					if (step_last) begin
						rem_q   <= '0;
						step_q  <= STEP_W'(RT_W);
						state_q <= ST_SQRT;
					end else begin
						rem_q  <= alu_cout ? alu_res : alu_a;
						step_q <= step_q - STEP_W'(1);
					end
				end

				// Digit-by-digit square root, two radicand bits per cycle
				ST_SQRT: begin
					rem_q  <= alu_cout ? alu_res : alu_a;
					num_q  <= {num_q[U_W-3:0], 2'b00};
					root_q <= {root_q[RT_W-2:0], alu_cout};
					step_q <= step_q - STEP_W'(1);
					if (step_last) begin
						state_q <= ST_OUT;
					end
				end

				// Load the result word and clear the series
				ST_OUT: begin
					if (out_load) begin
						out_mean_q  <= MEAN_W'(signed'(mean_q));
						out_std_q   <= STD_W'(root_q);
						out_count_q <= COUNT_W'(kept_q);
						if (ovf_q) begin
							out_status_q <= STAT_OVERFLOW;
						end else if (kept_q < CNT_W'(2)) begin
							out_status_q <= STAT_TOO_FEW;
						end else begin
							out_status_q <= STAT_OK;
						end
						prev_q  <= '0;
						seen_q  <= '0;
						kept_q  <= '0;
						sum_q   <= '0;
						ssq_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_status_q, out_count_q, out_std_q, out_mean_q};

endmodule

`default_nettype wire
